@@ rtl/batched_matmul_transpose_unit_assert.svh @@
// Assertion macros for the batched matrix multiply unit.
// Expects clk and arst_n in the scope of the including module.
`ifndef BATCHED_MATMUL_TRANSPOSE_UNIT_ASSERT_SVH
`define BATCHED_MATMUL_TRANSPOSE_UNIT_ASSERT_SVH

// same-cycle implication
`define BMT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication
`define BMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error("assertion failed");

`endif

@@ rtl/bmt_pkg.sv @@
// Package for the batched matrix multiply unit: sizes, codes, shared types
// and helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmt_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 16;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CALC_W     = 2 * DIM_W + 1;

	localparam int CMD_W      = 2;
	localparam int EIDX_W     = 6;
	localparam int EVAL_W     = 16;
	localparam int OUT_W      = 35;
	localparam int POS_W      = 3;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int SUM_W      = ((PROD_W > OUT_W) ? PROD_W : OUT_W) + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_DIM_W  = 4;
	localparam int BATCH_W    = 16;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_A   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_B   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_A   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_B   = 3'd6;

	localparam logic [CFG_DIM_W-1:0] RST_DIM   = 4'd8;
	localparam logic [BATCH_W-1:0]   RST_BATCH = 16'd1;
	localparam logic [BATCH_W-1:0]   ONE_BATCH = 16'd1;

	typedef struct packed {
		logic vld;
		logic first;
		logic lastk;
	} issue_t;

	typedef struct packed {
		logic             idle;
		logic             load_err;
		logic             last_el;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} seq_stat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0)
			r = DIM_W'(1);
		else if (int'(d) > MAX_DIM)
			r = DIM_W'(MAX_DIM);
		else
			r = DIM_W'(d);
		return r;
	endfunction

	// outer * stride + inner stays below stride * dim, so below DEPTH
	function automatic logic [ADDR_W-1:0] lin_addr(input logic [IDX_W-1:0] outer,
			input logic [DIM_W-1:0] stride, input logic [IDX_W-1:0] inner);
		logic [CALC_W-1:0] t;
		t = CALC_W'(outer) * CALC_W'(stride) + CALC_W'(inner);
		return t[ADDR_W-1:0];
	endfunction

	function automatic logic is_last(input logic [IDX_W-1:0] c, input logic [DIM_W-1:0] d);
		return (DIM_W'(c) + DIM_W'(1)) == d;
	endfunction

	function automatic logic in_store(input logic [EIDX_W-1:0] idx);
		return int'(idx) < DEPTH;
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [EIDX_W-1:0] idx);
		return ADDR_W'(idx);
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] to_store(
			input logic signed [EVAL_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] v);
		return POS_W'(v);
	endfunction

	function automatic logic signed [SUM_W-1:0] widen_prod(
			input logic signed [PROD_W-1:0] p);
		return SUM_W'(p);
	endfunction

	function automatic logic signed [SUM_W-1:0] widen_acc(
			input logic signed [OUT_W-1:0] a);
		return SUM_W'(a);
	endfunction

	// clamp to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-OUT_W:0]   hi;
		logic signed [OUT_W-1:0] r;
		hi = s[SUM_W-1:OUT_W-1];
		if ((&hi) || !(|hi))
			r = s[OUT_W-1:0];
		else if (s[SUM_W-1])
			r = {1'b1, {(OUT_W-1){1'b0}}};
		else
			r = {1'b0, {(OUT_W-1){1'b1}}};
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bmt_if.sv @@
// Request and result channel interfaces of the batched matrix multiply unit.
// Depends on bmt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmt_in_if;
	logic                                valid;
	logic                                ready;
	logic [bmt_pkg::CMD_W-1:0]           cmd;
	logic [bmt_pkg::EIDX_W-1:0]          elem_index;
	logic signed [bmt_pkg::EVAL_W-1:0]   elem_value;

	modport source(output valid, cmd, elem_index, elem_value, input ready);
	modport sink(input valid, cmd, elem_index, elem_value, output ready);
endinterface

interface bmt_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bmt_pkg::OUT_W-1:0]    product_sum;
	logic [bmt_pkg::POS_W-1:0]           out_row;
	logic [bmt_pkg::POS_W-1:0]           out_col;
	logic                                last;
	logic                                status;

	modport source(output valid, product_sum, out_row, out_col, last, status, input ready);
	modport sink(input valid, product_sum, out_row, out_col, last, status, output ready);
endinterface

`default_nettype wire

@@ rtl/bmt_store.sv @@
// Element store: one write port, one read port with registered read data.
// Depends on bmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmt_store (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [bmt_pkg::ADDR_W-1:0]           waddr,
	input  logic signed [bmt_pkg::DATA_WIDTH-1:0] wdata,
	input  logic [bmt_pkg::ADDR_W-1:0]           raddr,
	output logic signed [bmt_pkg::DATA_WIDTH-1:0] rdata
);

	logic signed [bmt_pkg::DATA_WIDTH-1:0] mem [bmt_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/bmt_mac.sv @@
// Shared multiply-accumulate unit: registered product, then saturating add.
// Depends on bmt_pkg; operands arrive in the cycle after each issue.
`timescale 1ns / 1ps
`default_nettype none

module bmt_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bmt_pkg::issue_t                       iss,
	input  logic signed [bmt_pkg::DATA_WIDTH-1:0] a_data,
	input  logic signed [bmt_pkg::DATA_WIDTH-1:0] b_data,
	output logic                                  done,
	output logic signed [bmt_pkg::OUT_W-1:0]      sum
);

	bmt_pkg::issue_t                     iss_s1;
	bmt_pkg::issue_t                     iss_s2;
	logic signed [bmt_pkg::PROD_W-1:0]   prod_s2;
	logic signed [bmt_pkg::OUT_W-1:0]    acc_q;
	logic                                done_q;
	logic signed [bmt_pkg::SUM_W-1:0]    sum_c;

	always_comb begin
		sum_c = bmt_pkg::widen_prod(prod_s2);
		if (!iss_s2.first)
			sum_c = sum_c + bmt_pkg::widen_acc(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			iss_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			iss_s1 <= iss;
			iss_s2 <= iss_s1;
			done_q <= iss_s2.vld & iss_s2.lastk;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_s1.vld)
			prod_s2 <= a_data * b_data;
		if (iss_s2.vld)
			acc_q <= bmt_pkg::sat_out(sum_c);
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

`default_nettype wire

@@ rtl/bmt_seq.sv @@
// Sequencer: walks rows, columns and the inner index, drives store reads
// and the MAC issue tags. Depends on bmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmt_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           start_err,
	input  logic [bmt_pkg::DIM_W-1:0]      di,
	input  logic [bmt_pkg::DIM_W-1:0]      dk,
	input  logic [bmt_pkg::DIM_W-1:0]      dj,
	input  logic                           ta,
	input  logic                           tb,
	input  logic                           out_free,
	input  logic                           mac_done,
	output bmt_pkg::issue_t                iss,
	output logic [bmt_pkg::ADDR_W-1:0]     a_addr,
	output logic [bmt_pkg::ADDR_W-1:0]     b_addr,
	output bmt_pkg::seq_stat_t             stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ARM   = 4'b0010,
		ST_ISSUE = 4'b0100,
		ST_DRAIN = 4'b1000
	} seq_state_t;

	seq_state_t                    state_q;
	logic [bmt_pkg::IDX_W-1:0]     i_q;
	logic [bmt_pkg::IDX_W-1:0]     j_q;
	logic [bmt_pkg::IDX_W-1:0]     k_q;
	logic                          err_q;
	logic                          i_last;
	logic                          j_last;
	logic                          k_last;

	always_comb begin
		i_last = bmt_pkg::is_last(i_q, di);
		j_last = bmt_pkg::is_last(j_q, dj);
		k_last = bmt_pkg::is_last(k_q, dk);
		a_addr = ta ? bmt_pkg::lin_addr(k_q, di, i_q) : bmt_pkg::lin_addr(i_q, dk, k_q);
		b_addr = tb ? bmt_pkg::lin_addr(j_q, dk, k_q) : bmt_pkg::lin_addr(k_q, dj, j_q);
		iss.vld       = (state_q == ST_ISSUE);
		iss.first     = (k_q == '0);
		iss.lastk     = k_last;
		stat.idle     = (state_q == ST_IDLE);
		stat.load_err = (state_q == ST_ARM) && out_free && err_q;
		stat.last_el  = i_last & j_last;
		stat.row      = bmt_pkg::to_pos(i_q);
		stat.col      = bmt_pkg::to_pos(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						err_q   <= start_err;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_ARM;
					end
				end
				// wait for the output register to free up
				ST_ARM: begin
					if (out_free) begin
						k_q     <= '0;
						state_q <= err_q ? ST_IDLE : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_last)
						state_q <= ST_DRAIN;
					else
						k_q <= k_q + 1'b1;
				end
				ST_DRAIN: begin
					if (mac_done) begin
						if (i_last && j_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_last) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= ST_ARM;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/batched_matmul_transpose_unit.sv @@
// Batched matrix multiply with transposes. Load requests are accepted while idle.
// Each result element takes one multiply-accumulate per cycle through the
// shared MAC while issuing, plus per-element pipeline drain and output stalls.
// A rejected start gives its error result through the arming state and the
// output register once that register is free. Async active-low reset clears
// control state and restores register defaults; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module batched_matmul_transpose_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmt_pkg::CFG_DATA_W-1:0]    cfg_data,
	bmt_in_if.sink                            request,
	bmt_out_if.source                         result
);

	logic [bmt_pkg::CFG_DIM_W-1:0]   rows_q;
	logic [bmt_pkg::CFG_DIM_W-1:0]   inner_q;
	logic [bmt_pkg::CFG_DIM_W-1:0]   cols_q;
	logic                            trans_a_q;
	logic                            trans_b_q;
	logic [bmt_pkg::BATCH_W-1:0]     batch_a_q;
	logic [bmt_pkg::BATCH_W-1:0]     batch_b_q;

	logic                                  req_fire;
	logic                                  we_a;
	logic                                  we_b;
	logic                                  start;
	logic                                  start_err;
	logic                                  out_free;
	logic [bmt_pkg::ADDR_W-1:0]            waddr;
	logic signed [bmt_pkg::DATA_WIDTH-1:0] wdata;
	logic [bmt_pkg::ADDR_W-1:0]            a_addr;
	logic [bmt_pkg::ADDR_W-1:0]            b_addr;
	logic signed [bmt_pkg::DATA_WIDTH-1:0] a_data;
	logic signed [bmt_pkg::DATA_WIDTH-1:0] b_data;
	bmt_pkg::issue_t                       iss;
	bmt_pkg::seq_stat_t                    stat;
	logic                                  mac_done;
	logic signed [bmt_pkg::OUT_W-1:0]      mac_sum;

	logic                                  out_vld_q;
	logic signed [bmt_pkg::OUT_W-1:0]      sum_q;
	logic [bmt_pkg::POS_W-1:0]             row_q;
	logic [bmt_pkg::POS_W-1:0]             col_q;
	logic                                  last_q;
	logic                                  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= bmt_pkg::RST_DIM;
			inner_q   <= bmt_pkg::RST_DIM;
			cols_q    <= bmt_pkg::RST_DIM;
			trans_a_q <= 1'b0;
			trans_b_q <= 1'b0;
			batch_a_q <= bmt_pkg::RST_BATCH;
			batch_b_q <= bmt_pkg::RST_BATCH;
		end else if (cfg_we) begin
			case (cfg_index)
				bmt_pkg::REG_ROWS_A:  rows_q    <= cfg_data[bmt_pkg::CFG_DIM_W-1:0];
				bmt_pkg::REG_INNER:   inner_q   <= cfg_data[bmt_pkg::CFG_DIM_W-1:0];
				bmt_pkg::REG_COLS_B:  cols_q    <= cfg_data[bmt_pkg::CFG_DIM_W-1:0];
				bmt_pkg::REG_TRANS_A: trans_a_q <= cfg_data[0];
				bmt_pkg::REG_TRANS_B: trans_b_q <= cfg_data[0];
				bmt_pkg::REG_BATCH_A: batch_a_q <= cfg_data[bmt_pkg::BATCH_W-1:0];
				bmt_pkg::REG_BATCH_B: batch_b_q <= cfg_data[bmt_pkg::BATCH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		req_fire  = request.valid & request.ready;
		we_a      = req_fire && (request.cmd == bmt_pkg::CMD_LOAD_A) &&
		            bmt_pkg::in_store(request.elem_index);
		we_b      = req_fire && (request.cmd == bmt_pkg::CMD_LOAD_B) &&
		            bmt_pkg::in_store(request.elem_index);
		start     = req_fire && (request.cmd == bmt_pkg::CMD_START);
		// broadcast of B only without transposes
		start_err = !((batch_a_q == batch_b_q) ||
		              ((batch_a_q > bmt_pkg::ONE_BATCH) && (batch_b_q == bmt_pkg::ONE_BATCH) &&
		               !trans_a_q && !trans_b_q));
		waddr     = bmt_pkg::to_addr(request.elem_index);
		wdata     = bmt_pkg::to_store(request.elem_value);
		out_free  = !out_vld_q || result.ready;
	end

	assign request.ready = stat.idle;

	bmt_store u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_addr),
		.rdata (a_data)
	);

	bmt_store u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (b_addr),
		.rdata (b_data)
	);

	bmt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_err (start_err),
		.di        (bmt_pkg::clamp_dim(rows_q)),
		.dk        (bmt_pkg::clamp_dim(inner_q)),
		.dj        (bmt_pkg::clamp_dim(cols_q)),
		.ta        (trans_a_q),
		.tb        (trans_b_q),
		.out_free  (out_free),
		.mac_done  (mac_done),
		.iss       (iss),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.stat      (stat)
	);

	bmt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.iss    (iss),
		.a_data (a_data),
		.b_data (b_data),
		.done   (mac_done),
		.sum    (mac_sum)
	);

	// output register: load on a finished element or a rejected start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (mac_done || stat.load_err)
			out_vld_q <= 1'b1;
		else if (result.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (mac_done) begin
			sum_q    <= mac_sum;
			row_q    <= stat.row;
			col_q    <= stat.col;
			last_q   <= stat.last_el;
			status_q <= 1'b0;
		end else if (stat.load_err) begin
			sum_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			last_q   <= 1'b1;
			status_q <= 1'b1;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.product_sum = sum_q;
	assign result.out_row     = row_q;
	assign result.out_col     = col_q;
	assign result.last        = last_q;
	assign result.status      = status_q;

`include "batched_matmul_transpose_unit_assert.svh"

	`BMT_ASSERT_IMPL(a_no_overwrite, out_vld_q && !result.ready, !(mac_done || stat.load_err))
	`BMT_ASSERT_IMPL(a_done_busy, mac_done, !stat.idle)
	`BMT_ASSERT_NEXT(a_last_idle, mac_done && stat.last_el, stat.idle)

endmodule

`default_nettype wire
